>>> rtl/core/blecw_pkg.sv
// Shared types, constants and bit-level functions for the BLE CRC and whitening encoder
package blecw_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CrcW   = 24;
	localparam int unsigned ChanW  = 6;

	localparam logic [CrcW-1:0]  CRC_POLY     = 24'h00065B;
	localparam logic [CrcW-1:0]  CRC_PRESET_R = 24'h555555;
	localparam logic [ByteW-1:0] WHITEN_TAPS  = 8'h11;
	localparam logic [ByteW-1:0] SEED_SET     = 8'h02;
	localparam logic [ChanW-1:0] CHANNEL_R    = 6'd37;

	// configuration register indexes
	localparam logic CFG_CHANNEL = 1'b0;
	localparam logic CFG_PRESET  = 1'b1;

	// sequencer phase: data byte, then the three appended crc bytes
	typedef enum logic [1:0] {
		PH_DATA    = 2'd0,
		PH_CRC_HI  = 2'd1,
		PH_CRC_MID = 2'd2,
		PH_CRC_LO  = 2'd3
	} phase_t;

	// one input transaction held in the input register
	typedef struct packed {
		logic [ByteW-1:0] pdu_byte;
		logic             packet_start;
		logic             packet_end;
	} item_t;

	// settings handed from the register bank to the engine
	typedef struct packed {
		logic [ByteW-1:0] seed;
		logic [CrcW-1:0]  preset;
	} cfg_t;

	// whitened byte together with the advanced shift register
	typedef struct packed {
		logic [ByteW-1:0] lfsr;
		logic [ByteW-1:0] data;
	} whiten_t;

	// bit order reversal of one byte
	function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] a);
		logic [ByteW-1:0] r;
		for (int i = 0; i < ByteW; i++) begin
			r[ByteW-1-i] = a[i];
		end
		return r;
	endfunction

	// fold one byte into the crc, lsb first
	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
			input logic [ByteW-1:0] d);
		logic [CrcW-1:0] c;
		logic            top;
		c = crc;
		for (int i = 0; i < ByteW; i++) begin
			top = c[CrcW-1];
			c   = {c[CrcW-2:0], 1'b0};
			if (top != d[i]) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// whiten one byte, lsb first, msb of the shift register drives each bit
	function automatic whiten_t whiten_byte(input logic [ByteW-1:0] lfsr,
			input logic [ByteW-1:0] d);
		whiten_t r;
		r.lfsr = lfsr;
		r.data = d;
		for (int i = 0; i < ByteW; i++) begin
			if (r.lfsr[ByteW-1]) begin
				r.lfsr    = r.lfsr ^ WHITEN_TAPS;
				r.data[i] = ~r.data[i];
			end
			r.lfsr = {r.lfsr[ByteW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/ble_pdu_crc_whiten_encoder_core.sv
// Top level of the BLE PDU CRC-24 and whitening encoder
// Each input transaction goes through the input register and then the result register to m_axis.
// Throughput: one PDU byte per cycle while m_axis accepts; after a final byte, the single result
// register sends the three CRC bytes in turn, and no input is taken until all three are out.
// Reset: asynchronous, active low; channel 37, CRC preset and CRC 0x555555, whitening register zero.
// Configuration writes are always accepted and take effect on the next packet start.
module ble_pdu_crc_whiten_encoder_core
	import blecw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CrcW-1:0]  cfg_data,
	// input stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [ByteW-1:0] s_axis_tdata,  // [7:0] pdu_byte
	input  logic             s_axis_tuser,  // packet_start
	input  logic             s_axis_tlast,  // packet_end
	// output stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [ByteW-1:0] m_axis_tdata,  // [7:0] air_byte
	output logic             m_axis_tlast   // air_last
);

	logic [ChanW-1:0] channel_q;
	logic [CrcW-1:0]  preset_q;
	logic             valid_s1;
	item_t            item_s1;
	logic             item_take;
	cfg_t             cfg;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= CHANNEL_R;
			preset_q  <= CRC_PRESET_R;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHANNEL: channel_q <= cfg_data[ChanW-1:0];
				CFG_PRESET:  preset_q  <= cfg_data;
				default:     preset_q  <= preset_q;
			endcase
		end
	end

	// whitening seed from the reversed channel
	assign cfg = '{seed: rev8({2'b00, channel_q}) | SEED_SET, preset: preset_q};

	// input register
	assign s_axis_tready = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.pdu_byte     <= s_axis_tdata;
			item_s1.packet_start <= s_axis_tuser;
			item_s1.packet_end   <= s_axis_tlast;
		end
	end

	blecw_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (valid_s1),
		.item          (item_s1),
		.cfg           (cfg),
		.item_take     (item_take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> rtl/core/blecw_engine.sv
// CRC and whitening engine: running state, crc byte sequencer and result register
module blecw_engine
	import blecw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  item_t            item,
	input  cfg_t             cfg,
	output logic             item_take,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [ByteW-1:0] m_axis_tdata,  // [7:0] air_byte
	output logic             m_axis_tlast   // air_last
);

	phase_t          phase_q, phase_d;
	logic [CrcW-1:0] crc_q;
	logic [ByteW-1:0] lfsr_q;
	logic            out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic            out_last_q;

	logic            out_free;
	logic            crc_emit;
	logic [CrcW-1:0] crc_base;
	logic [CrcW-1:0] crc_new;
	logic [ByteW-1:0] lfsr_base;
	whiten_t         w_data;
	whiten_t         w_crc;
	logic [ByteW-1:0] crc_sel;

	// result register can take a new transaction
	assign out_free = !out_valid_q || m_axis_tready;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_DATA: begin
				if (item_valid && out_free && item.packet_end) phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				if (out_free) phase_d = PH_CRC_MID;
			end
			PH_CRC_MID: begin
				if (out_free) phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				if (out_free) phase_d = PH_DATA;
			end
			default: phase_d = PH_DATA;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_take = 1'b0;
		crc_emit  = 1'b0;
		crc_sel   = crc_q[23:16];
		unique case (phase_q)
			PH_DATA: begin
				item_take = item_valid && out_free;
			end
			PH_CRC_HI: begin
				crc_emit = out_free;
				crc_sel  = crc_q[23:16];
			end
			PH_CRC_MID: begin
				crc_emit = out_free;
				crc_sel  = crc_q[15:8];
			end
			PH_CRC_LO: begin
				crc_emit = out_free;
				crc_sel  = crc_q[7:0];
			end
			default: begin
				item_take = 1'b0;
			end
		endcase
	end

	// data byte path, with preset and seed reload on packet start
	assign crc_base  = item.packet_start ? cfg.preset : crc_q;
	assign lfsr_base = item.packet_start ? cfg.seed : lfsr_q;
	assign crc_new   = crc_byte(crc_base, item.pdu_byte);
	assign w_data    = whiten_byte(lfsr_base, item.pdu_byte);

	// crc byte path, whitened in reversed bit order
	assign w_crc = whiten_byte(lfsr_q, rev8(crc_sel));

	// running state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			crc_q   <= CRC_PRESET_R;
			lfsr_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (item_take) begin
				crc_q  <= crc_new;
				lfsr_q <= w_data.lfsr;
			end else if (crc_emit) begin
				lfsr_q <= w_crc.lfsr;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take || crc_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (item_take) begin
			out_byte_q <= rev8(w_data.data);
			out_last_q <= 1'b0;
		end else if (crc_emit) begin
			out_byte_q <= rev8(w_crc.data);
			out_last_q <= (phase_q == PH_CRC_LO);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// a final byte starts the crc sequence
	a_end_starts_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && item.packet_end) |=> (phase_q == PH_CRC_HI))
		else $error("crc sequence did not start after packet end");

	// crc stays frozen while its bytes are sent
	a_crc_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_DATA) |=> $stable(crc_q))
		else $error("crc changed during crc byte output");

	// the lowest crc byte is marked last
	a_last_on_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(crc_emit && phase_q == PH_CRC_LO) |=> (out_valid_q && out_last_q))
		else $error("last crc byte not marked");

	// no input is taken while crc bytes are pending
	a_no_take_in_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CRC_HI || phase_q == PH_CRC_MID) |=> !item_take)
		else $error("input taken during crc output");

endmodule

>>> verif/ble_pdu_crc_whiten_encoder_core_test.sv
// Testbench for the BLE PDU CRC-24 and whitening encoder: random streams checked against a predictor
`timescale 1ns / 100ps

module ble_pdu_crc_whiten_encoder_core_test;
	import blecw_pkg::*;

	// one byte as it goes out on air
	typedef struct packed {
		logic [ByteW-1:0] air_byte;
		logic             air_last;
	} air_t;

	// predicts air bytes from accepted pdu bytes and checks the output stream
	class air_byte_scoreboard;
		logic [ChanW-1:0] chan;
		logic [CrcW-1:0]  preset;
		logic [CrcW-1:0]  crc;
		logic [ByteW-1:0] lfsr;
		air_t             air_q[$];
		int unsigned      errors;
		int unsigned      checked;

		function new();
			chan    = CHANNEL_R;
			preset  = CRC_PRESET_R;
			crc     = CRC_PRESET_R;
			lfsr    = '0;
			errors  = 0;
			checked = 0;
		endfunction

		function logic [ByteW-1:0] bit_flip(logic [ByteW-1:0] a);
			logic [ByteW-1:0] r;
			for (int i = 0; i < ByteW; i++) begin
				r[ByteW-1-i] = a[i];
			end
			return r;
		endfunction

		// crc shift register, data lsb first, msb out
		function logic [CrcW-1:0] crc_fold(logic [CrcW-1:0] c, logic [ByteW-1:0] d);
			logic t;
			for (int i = 0; i < ByteW; i++) begin
				t = c[CrcW-1];
				c = {c[CrcW-2:0], 1'b0};
				if (t != d[i]) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		// whitening advances the running lfsr
		function logic [ByteW-1:0] whiten_step(logic [ByteW-1:0] d);
			for (int i = 0; i < ByteW; i++) begin
				if (lfsr[ByteW-1]) begin
					lfsr = lfsr ^ WHITEN_TAPS;
					d[i] = ~d[i];
				end
				lfsr = {lfsr[ByteW-2:0], 1'b0};
			end
			return d;
		endfunction

		function void set_register(logic idx, logic [CrcW-1:0] value);
			if (idx == CFG_CHANNEL) begin
				chan = value[ChanW-1:0];
			end else begin
				preset = value;
			end
		endfunction

		function void note_pdu_byte(logic [ByteW-1:0] b, logic st, logic en);
			air_t             r;
			logic [ByteW-1:0] c;
			if (st) begin
				crc  = preset;
				lfsr = bit_flip({2'b00, chan}) | SEED_SET;
			end
			crc        = crc_fold(crc, b);
			r.air_byte = bit_flip(whiten_step(b));
			r.air_last = 1'b0;
			air_q.push_back(r);
			// trailing crc bytes, high byte first
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					c          = crc[CrcW-1-8*k -: 8];
					r.air_byte = bit_flip(whiten_step(bit_flip(c)));
					r.air_last = (k == 2);
					air_q.push_back(r);
				end
			end
		endfunction

		function void check_air_byte(logic [ByteW-1:0] b, logic last);
			air_t e;
			checked++;
			if (air_q.size() == 0) begin
				$error("unexpected air byte 0x%02h (last %0d)", b, last);
				errors++;
				return;
			end
			e = air_q.pop_front();
			if (b !== e.air_byte) begin
				$error("air_byte mismatch: expected 0x%02h, actual 0x%02h", e.air_byte, b);
				errors++;
			end
			if (last !== e.air_last) begin
				$error("air_last mismatch: expected %0d, actual %0d", e.air_last, last);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return air_q.size();
		endfunction
	endclass

	localparam int unsigned STALL_LIMIT = 5000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = CFG_CHANNEL;
	logic [CrcW-1:0]  cfg_data = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [ByteW-1:0] s_axis_tdata = '0;  // [7:0] pdu_byte
	logic             s_axis_tuser = 1'b0; // packet_start
	logic             s_axis_tlast = 1'b0; // packet_end
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [ByteW-1:0] m_axis_tdata;       // [7:0] air_byte
	logic             m_axis_tlast;       // air_last

	air_byte_scoreboard sb = new();

	int unsigned snd_idle_pct = 0;
	int unsigned rcv_stall_pct = 0;
	logic        hold_off = 1'b0;
	int unsigned stall_cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned packets_sent = 0;
	int unsigned settings_used = 1;

	ble_pdu_crc_whiten_encoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= !hold_off && ($urandom_range(99) >= rcv_stall_pct);
	end

	// output transactions go straight to the scoreboard
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_air_byte(m_axis_tdata, m_axis_tlast);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d air bytes outstanding", sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// offer one pdu byte, with random idle cycles ahead of it
	task automatic send_item(input logic [ByteW-1:0] b, input logic st, input logic en);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= st;
		s_axis_tlast  <= en;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		sb.note_pdu_byte(b, st, en);
		bytes_sent++;
	endtask

	// well-formed packet with random content; optionally cut short
	task automatic send_packet(input int unsigned len, input bit cut);
		for (int unsigned i = 0; i < len; i++) begin
			send_item(8'($urandom_range(255)), i == 0, !cut && (i == len - 1));
		end
		packets_sent++;
	endtask

	// wait for the block to run empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CrcW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		sb.set_register(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [ChanW-1:0] ch, input logic [CrcW-1:0] pre);
		drain();
		write_reg(CFG_CHANNEL, {{(CrcW-ChanW){1'b0}}, ch});
		write_reg(CFG_PRESET, pre);
		settings_used++;
	endtask

	// mostly packets, some stray bytes and truncated packets
	task automatic random_traffic(input int unsigned n);
		int unsigned start_count;
		start_count = bytes_sent;
		while (bytes_sent - start_count < n) begin
			if ($urandom_range(9) == 0) begin
				send_item(8'($urandom_range(255)), $urandom_range(3) == 0,
					$urandom_range(3) == 0);
			end else begin
				send_packet($urandom_range(1, 12), $urandom_range(9) == 0);
			end
		end
	endtask

	// receiver held off for a fixed stretch
	task automatic hold_receiver(input int unsigned cycles);
		hold_off <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: bytes with no start, whitening off
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		// one-byte packet, then bytes continuing after its end
		send_item(8'hA5, 1'b1, 1'b1);
		send_item(8'h3C, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		// field extremes in a default-channel packet
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'h01, 1'b0, 1'b0);
		send_item(8'h7F, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);

		// channel beyond the advertising range, preset extremes
		set_config(6'd63, 24'h000000);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'hAA, 1'b0, 1'b0);
		send_item(8'h0F, 1'b0, 1'b1);
		set_config(6'd0, 24'hFFFFFF);
		send_item(8'hF0, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		set_config(6'd39, 24'hA5C3E1);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h12, 1'b0, 1'b1);
		set_config(6'd40, 24'h5A3C1E);
		send_item(8'h00, 1'b1, 1'b1);

		// random phases under different idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 0;  rcv_stall_pct <= 0;  end
				1: begin snd_idle_pct = 70; rcv_stall_pct <= 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct <= 70; end
				default: begin snd_idle_pct = 23; rcv_stall_pct <= 23; end
			endcase
			set_config(6'($urandom_range(63)),
				{8'($urandom_range(255)), 16'($urandom_range(65535))});
			random_traffic(50);
		end

		// back-pressure: receiver held off while long packets keep coming
		snd_idle_pct = 0;
		rcv_stall_pct <= 0;
		set_config(6'($urandom_range(39)),
			{8'($urandom_range(255)), 16'($urandom_range(65535))});
		fork
			hold_receiver(300);
			begin
				send_packet(12, 1'b0);
				send_packet(12, 1'b0);
				send_packet(12, 1'b0);
			end
		join

		drain();
		$display("sent %0d pdu bytes (%0d packets) under %0d register settings",
			bytes_sent, packets_sent, settings_used);
		$display("checked %0d air bytes across idle, stall and hold-off phases", sb.checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
